// ===== design/mrtu_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mrtu_pkg: shared types and constants of the Modbus RTU frame checker
// Holds the frame size limit, the status codes, the word and result records
// and the CRC-16/MODBUS byte update.
// ----------------------------------------------------------------------------
package mrtu_pkg;

    localparam int MAX_FRAME = 256;
    localparam int CNT_W     = $clog2(MAX_FRAME + 1);
    localparam int FLEN_W    = 9;
    localparam int MIN_FRAME = 8;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;
    localparam logic [7:0]  SLAVE_ADDR_RESET = 8'd1;
    localparam logic [7:0]  BROADCAST_ADDR   = 8'd0;

    typedef enum logic [1:0] {
        ST_ACCEPTED  = 2'd0,
        ST_SHORT     = 2'd1,
        ST_ADDR_MISS = 2'd2,
        ST_CRC_MISS  = 2'd3
    } t_status;

    // One received frame byte with its end-of-frame flag.
    typedef struct packed {
        logic [7:0] data_byte;
        logic       frame_end;
    } t_word;

    // One frame verdict with the decoded header.
    typedef struct packed {
        logic [FLEN_W-1:0] frame_length;
        logic [15:0]       length_word;
        logic [15:0]       register_word;
        logic [7:0]        command;
        logic              broadcast;
        t_status           status;
    } t_result;

    // Reflected CRC-16 update by one byte, LSB first.
    function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage
`default_nettype wire

// ===== design/mrtu_in_reg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mrtu_in_reg: input word register
// Captures one received word and holds it until the frame core takes it.
// ----------------------------------------------------------------------------
module mrtu_in_reg
    import mrtu_pkg::*;
(
    input  wire   i_clk,
    input  wire   i_rst_n,
    input  wire   i_valid,
    output logic  o_ready,
    input  t_word i_word,
    output logic  o_valid,
    output t_word o_word,
    input  wire   i_take
);

    logic  r_valid;
    t_word r_word;

    assign o_ready = !r_valid || i_take;
    assign o_valid = r_valid;
    assign o_word  = r_word;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_word <= i_word;
        end
    end

endmodule
`default_nettype wire

// ===== design/mrtu_frame.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mrtu_frame: frame state and verdict
// Stores header bytes, runs the CRC two bytes behind the stored tail and
// judges the frame on its last byte.
// ----------------------------------------------------------------------------
module mrtu_frame
    import mrtu_pkg::*;
(
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_cfg_wr_en,
    input  wire  [7:0]  i_cfg_wr_data,
    input  wire         i_valid,
    input  t_word       i_word,
    input  wire         i_out_space,
    output logic        o_take,
    output logic        o_res_valid,
    output t_result     o_res
);

    logic [7:0]       r_slave_addr;
    logic [15:0]      r_crc, n_crc, a_crc;
    logic [CNT_W-1:0] r_cnt, n_cnt, a_cnt;
    logic [15:0]      r_tail, n_tail, a_tail;
    logic [7:0]       r_addr, n_addr, a_addr;
    logic [7:0]       r_cmd, n_cmd, a_cmd;
    logic [15:0]      r_reg, n_reg, a_reg;
    logic [15:0]      r_len, n_len, a_len;
    logic [7:0]       b;
    t_status          status;

    assign b           = i_word.data_byte;
    // A word that ends a frame waits for room in the result register.
    assign o_take      = i_valid && (!i_word.frame_end || i_out_space);
    assign o_res_valid = o_take && i_word.frame_end;

    // Frame state after storing this byte.
    always_comb begin
        a_crc  = r_crc;
        a_cnt  = r_cnt;
        a_tail = r_tail;
        a_addr = r_addr;
        a_cmd  = r_cmd;
        a_reg  = r_reg;
        a_len  = r_len;
        if (r_cnt < CNT_W'(MAX_FRAME)) begin
            if (r_cnt >= CNT_W'(2)) begin
                a_crc = crc_feed(r_crc, r_tail[15:8]);
            end
            a_tail = {r_tail[7:0], b};
            if (r_cnt == CNT_W'(0)) begin
                a_addr = b;
            end
            if (r_cnt == CNT_W'(1)) begin
                a_cmd = b;
            end
            if (r_cnt == CNT_W'(2)) begin
                a_reg = {b, 8'h00};
            end
            if (r_cnt == CNT_W'(3)) begin
                a_reg = {r_reg[15:8], b};
            end
            if (r_cnt == CNT_W'(4)) begin
                a_len = {b, 8'h00};
            end
            if (r_cnt == CNT_W'(5)) begin
                a_len = {r_len[15:8], b};
            end
            a_cnt = r_cnt + CNT_W'(1);
        end
    end

    // Checks are ordered: length, then address, then CRC.
    always_comb begin
        priority if (a_cnt < CNT_W'(MIN_FRAME)) begin
            status = ST_SHORT;
        end else if (a_addr != BROADCAST_ADDR && a_addr != r_slave_addr) begin
            status = ST_ADDR_MISS;
        end else if (a_crc[7:0] == a_tail[15:8] && a_crc[15:8] == a_tail[7:0]) begin
            status = ST_ACCEPTED;
        end else begin
            status = ST_CRC_MISS;
        end
    end

    always_comb begin
        o_res.status        = status;
        o_res.broadcast     = (a_addr == BROADCAST_ADDR);
        o_res.command       = a_cmd;
        o_res.register_word = a_reg;
        o_res.length_word   = a_len;
        o_res.frame_length  = FLEN_W'(a_cnt);
    end

    always_comb begin
        n_crc  = r_crc;
        n_cnt  = r_cnt;
        n_tail = r_tail;
        n_addr = r_addr;
        n_cmd  = r_cmd;
        n_reg  = r_reg;
        n_len  = r_len;
        if (o_take) begin
            if (i_word.frame_end) begin
                n_crc  = CRC_INIT;
                n_cnt  = '0;
                n_tail = '0;
                n_addr = '0;
                n_cmd  = '0;
                n_reg  = '0;
                n_len  = '0;
            end else begin
                n_crc  = a_crc;
                n_cnt  = a_cnt;
                n_tail = a_tail;
                n_addr = a_addr;
                n_cmd  = a_cmd;
                n_reg  = a_reg;
                n_len  = a_len;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slave_addr <= SLAVE_ADDR_RESET;
            r_crc        <= CRC_INIT;
            r_cnt        <= '0;
            r_tail       <= '0;
            r_addr       <= '0;
            r_cmd        <= '0;
            r_reg        <= '0;
            r_len        <= '0;
        end else begin
            if (i_cfg_wr_en) begin
                r_slave_addr <= i_cfg_wr_data;
            end
            r_crc  <= n_crc;
            r_cnt  <= n_cnt;
            r_tail <= n_tail;
            r_addr <= n_addr;
            r_cmd  <= n_cmd;
            r_reg  <= n_reg;
            r_len  <= n_len;
        end
    end

    a_count_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> r_cnt <= CNT_W'(MAX_FRAME))
        else $error("frame byte count beyond buffer size");

    a_clear_after_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |=> (r_cnt == '0 && r_crc == CRC_INIT && r_tail == '0))
        else $error("frame state not cleared after frame end");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_take && !i_word.frame_end && r_cnt < CNT_W'(MAX_FRAME))
            |=> r_cnt == $past(r_cnt) + CNT_W'(1))
        else $error("stored byte not counted");

    a_result_needs_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |-> i_out_space)
        else $error("frame verdict issued without room in result register");

endmodule
`default_nettype wire

// ===== design/mrtu_out_reg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mrtu_out_reg: result register
// Holds one frame verdict until the downstream side takes it.
// ----------------------------------------------------------------------------
module mrtu_out_reg
    import mrtu_pkg::*;
(
    input  wire     i_clk,
    input  wire     i_rst_n,
    input  wire     i_load,
    input  t_result i_res,
    output logic    o_space,
    output logic    o_valid,
    output t_result o_res,
    input  wire     i_ready
);

    logic    r_valid;
    t_result r_res;

    assign o_space = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_res   = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_space) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_space && i_load) begin
            r_res <= i_res;
        end
    end

endmodule
`default_nettype wire

// ===== design/modbus_rtu_frame_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// modbus_rtu_frame_checker: Modbus RTU frame check with CRC-16/MODBUS
// Judges received RTU frames and reports the status and decoded header.
// ----------------------------------------------------------------------------
// Each word carries one received frame byte; tlast marks the last byte before
// the idle gap. A word is taken every clock cycle unless a closing byte is held
// back: it passes through an input register, the frame state and the CRC are
// updated by one byte as the frame core takes it from there, and a frame end
// writes one verdict word into the result register, which offers it downstream.
// The throughput of one word per cycle is set by the combinational CRC byte
// update; only a closing byte meeting a full, stalled result register waits.
// Up to 256 bytes are kept per frame and later ones are dropped. The CRC runs
// over all stored bytes except the last two, which must carry it low byte
// first. The status is accepted, too short (fewer than 8 bytes), address
// mismatch (neither the broadcast address 0 nor the slave address) or CRC
// mismatch, checked in that order. The slave address register resets to 1 and
// is written with i_cfg_wr_en; write it only while no frame is in flight.
// ----------------------------------------------------------------------------
module modbus_rtu_frame_checker
    import mrtu_pkg::*;
(
    input  wire         i_clk,
    input  wire         i_rst_n,
    // Slave address register write.
    input  wire         i_cfg_wr_en,
    input  wire  [7:0]  i_cfg_wr_data,
    // Received byte stream.
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire  [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  wire         s_axis_tlast,   // frame_end
    // Verdict stream.
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [55:0] m_axis_tdata    // [1:0] status, [2] broadcast,
                                        // [10:3] command, [26:11] register_word,
                                        // [42:27] length_word,
                                        // [51:43] frame_length, [55:52] zero
);

    t_word   in_word;
    t_word   held_word;
    logic    held_valid;
    logic    take;
    logic    out_space;
    logic    res_valid;
    t_result res;
    t_result out_res;

    assign in_word.data_byte = s_axis_tdata;
    assign in_word.frame_end = s_axis_tlast;

    mrtu_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_word  (in_word),
        .o_valid (held_valid),
        .o_word  (held_word),
        .i_take  (take)
    );

    mrtu_frame u_frame (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_valid       (held_valid),
        .i_word        (held_word),
        .i_out_space   (out_space),
        .o_take        (take),
        .o_res_valid   (res_valid),
        .o_res         (res)
    );

    mrtu_out_reg u_out_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (res_valid),
        .i_res   (res),
        .o_space (out_space),
        .o_valid (m_axis_tvalid),
        .o_res   (out_res),
        .i_ready (m_axis_tready)
    );

    // Fields packed from the lowest bit up, padded to whole bytes.
    assign m_axis_tdata = {4'b0000,
                           out_res.frame_length,
                           out_res.length_word,
                           out_res.register_word,
                           out_res.command,
                           out_res.broadcast,
                           out_res.status};

endmodule
`default_nettype wire
